// ===== rtl/rau_pkg.sv =====
// ----------------------------------------------------------------------------
// rau_pkg
// Shared widths, codes and controller/datapath signal types for the rational
// arithmetic unit.
// ----------------------------------------------------------------------------
package rau_pkg;

  localparam int OP_W      = 2;
  localparam int NUM_W     = 32;
  localparam int DEN_W     = 31;
  localparam int ST_W      = 2;
  localparam int PROD_W    = 64;
  localparam int TWOS_W    = 6;
  localparam int CNT_W     = 6;
  localparam int RES_W_DEF = 32;

  localparam logic [OP_W-1:0] OP_ADD = 2'd0;
  localparam logic [OP_W-1:0] OP_SUB = 2'd1;
  localparam logic [OP_W-1:0] OP_MUL = 2'd2;
  localparam logic [OP_W-1:0] OP_DIV = 2'd3;

  localparam logic [ST_W-1:0] ST_OK   = 2'd0;
  localparam logic [ST_W-1:0] ST_DIV0 = 2'd1;
  localparam logic [ST_W-1:0] ST_OVF  = 2'd2;

  typedef enum logic [3:0] {
    C_NONE,
    C_LOAD,
    C_M0,
    C_M1,
    C_M2,
    C_M3,
    C_MAG,
    C_GINIT,
    C_GTWO,
    C_GODD,
    C_GSTEP,
    C_GFIN,
    C_DINIT,
    C_DSTEP,
    C_FIN
  } rau_cmd_t;

  typedef struct packed {
    logic both_even;
    logic u_even;
    logic v_zero;
    logic div_last;
    logic early;
  } rau_sts_t;

endpackage

// ===== rtl/rau_if.sv =====
// ----------------------------------------------------------------------------
// rau_if
// Valid/ready channels of the rational arithmetic unit: operand transactions
// in, result transactions out.
// ----------------------------------------------------------------------------
interface rau_in_if;
  logic                              valid;
  logic                              ready;
  logic [rau_pkg::OP_W-1:0]          op;
  logic signed [rau_pkg::NUM_W-1:0]  a_num;
  logic [rau_pkg::DEN_W-1:0]         a_den;
  logic signed [rau_pkg::NUM_W-1:0]  b_num;
  logic [rau_pkg::DEN_W-1:0]         b_den;

  modport source (output valid, op, a_num, a_den, b_num, b_den, input ready);
  modport sink   (input valid, op, a_num, a_den, b_num, b_den, output ready);
endinterface

interface rau_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [rau_pkg::NUM_W-1:0]  res_num;
  logic [rau_pkg::DEN_W-1:0]         res_den;
  logic [rau_pkg::ST_W-1:0]          status;

  modport source (output valid, res_num, res_den, status, input ready);
  modport sink   (input valid, res_num, res_den, status, output ready);
endinterface

// ===== rtl/rau_dp.sv =====
// ----------------------------------------------------------------------------
// rau_dp
// Datapath: shared signed multiplier, magnitude and sign, binary GCD and two
// bit-serial dividers by the GCD, result register with range check.
// ----------------------------------------------------------------------------
module rau_dp #(
  parameter int WIDTH = rau_pkg::RES_W_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  rau_pkg::rau_cmd_t                cmd,
  input  logic [rau_pkg::OP_W-1:0]         op,
  input  logic signed [rau_pkg::NUM_W-1:0] a_num,
  input  logic [rau_pkg::DEN_W-1:0]        a_den,
  input  logic signed [rau_pkg::NUM_W-1:0] b_num,
  input  logic [rau_pkg::DEN_W-1:0]        b_den,
  output rau_pkg::rau_sts_t                sts,
  output logic signed [rau_pkg::NUM_W-1:0] res_num,
  output logic [rau_pkg::DEN_W-1:0]        res_den,
  output logic [rau_pkg::ST_W-1:0]         status
);

  localparam int PW = rau_pkg::PROD_W;
  localparam logic [PW-1:0] LIM = PW'(1) << (WIDTH - 1);

  logic [rau_pkg::OP_W-1:0]          op_r;
  logic signed [rau_pkg::NUM_W-1:0]  an_r, bn_r, mx, my;
  logic [rau_pkg::DEN_W-1:0]         ad_r, bd_r;
  logic signed [PW-1:0]              prod_r, n_r, d_r;
  logic [PW-1:0]                     nmag, dmag;
  logic [PW-1:0]                     u_r, v_r, g_r, qn_r, qd_r, rn_r, rd_r;
  logic [rau_pkg::TWOS_W-1:0]        twos_r;
  logic [rau_pkg::CNT_W-1:0]         cnt_r;
  logic                              neg_r, early_r, ezero_r;
  logic [PW:0]                       tn, td;
  logic                              ovf;
  logic signed [rau_pkg::NUM_W-1:0]  res_num_r;
  logic [rau_pkg::DEN_W-1:0]         res_den_r;
  logic [rau_pkg::ST_W-1:0]          status_r;

  // multiplier operand select
  always_comb begin
    mx = an_r;
    my = (op_r == rau_pkg::OP_MUL) ? bn_r : {1'b0, bd_r};
    case (cmd)
      rau_pkg::C_M1: begin
        mx = bn_r;
        my = {1'b0, ad_r};
      end
      rau_pkg::C_M2: begin
        mx = {1'b0, ad_r};
        my = (op_r == rau_pkg::OP_DIV) ? bn_r : {1'b0, bd_r};
      end
      default: ;
    endcase
  end

  assign nmag = n_r[PW-1] ? PW'(-n_r) : PW'(n_r);
  assign dmag = d_r[PW-1] ? PW'(-d_r) : PW'(d_r);

  assign tn = {rn_r, qn_r[PW-1]};
  assign td = {rd_r, qd_r[PW-1]};

  assign ovf = (qd_r > LIM - PW'(1)) || (neg_r ? (qn_r > LIM) : (qn_r > LIM - PW'(1)));

  always_ff @(posedge clk) begin
    case (cmd)
      rau_pkg::C_LOAD: begin
        op_r <= op;
        an_r <= a_num;
        ad_r <= a_den;
        bn_r <= b_num;
        bd_r <= b_den;
      end
      rau_pkg::C_M0: prod_r <= mx * my;
      rau_pkg::C_M1: begin
        n_r    <= prod_r;
        prod_r <= mx * my;
      end
      rau_pkg::C_M2: begin
        if (op_r == rau_pkg::OP_ADD) n_r <= n_r + prod_r;
        else if (op_r == rau_pkg::OP_SUB) n_r <= n_r - prod_r;
        prod_r <= mx * my;
      end
      rau_pkg::C_M3: d_r <= prod_r;
      rau_pkg::C_MAG: begin
        qn_r  <= nmag;
        qd_r  <= dmag;
        neg_r <= n_r[PW-1] ^ d_r[PW-1];
        if (op_r == rau_pkg::OP_DIV && bn_r == '0) begin
          early_r <= 1'b1;
          ezero_r <= 1'b0;
        end else if (nmag == '0) begin
          early_r <= 1'b1;
          ezero_r <= 1'b1;
        end else begin
          early_r <= (dmag == '0);
          ezero_r <= 1'b0;
        end
      end
      rau_pkg::C_GINIT: begin
        u_r    <= qn_r;
        v_r    <= qd_r;
        twos_r <= '0;
      end
      rau_pkg::C_GTWO: begin
        if (!(u_r[0] | v_r[0])) begin
          u_r    <= u_r >> 1;
          v_r    <= v_r >> 1;
          twos_r <= twos_r + 1'b1;
        end
      end
      rau_pkg::C_GODD: if (!u_r[0]) u_r <= u_r >> 1;
      rau_pkg::C_GSTEP: begin
        if (v_r != '0) begin
          if (!v_r[0]) v_r <= v_r >> 1;
          else if (u_r > v_r) begin
            u_r <= v_r;
            v_r <= u_r - v_r;
          end else v_r <= v_r - u_r;
        end
      end
      rau_pkg::C_GFIN: g_r <= u_r << twos_r;
      rau_pkg::C_DINIT: begin
        rn_r  <= '0;
        rd_r  <= '0;
        cnt_r <= '0;
      end
      rau_pkg::C_DSTEP: begin
        if (tn >= {1'b0, g_r}) begin
          rn_r <= PW'(tn - {1'b0, g_r});
          qn_r <= {qn_r[PW-2:0], 1'b1};
        end else begin
          rn_r <= tn[PW-1:0];
          qn_r <= {qn_r[PW-2:0], 1'b0};
        end
        if (td >= {1'b0, g_r}) begin
          rd_r <= PW'(td - {1'b0, g_r});
          qd_r <= {qd_r[PW-2:0], 1'b1};
        end else begin
          rd_r <= td[PW-1:0];
          qd_r <= {qd_r[PW-2:0], 1'b0};
        end
        cnt_r <= cnt_r + 1'b1;
      end
      rau_pkg::C_FIN: begin
        if (early_r) begin
          res_num_r <= '0;
          res_den_r <= ezero_r ? rau_pkg::DEN_W'(1) : '0;
          status_r  <= ezero_r ? rau_pkg::ST_OK : rau_pkg::ST_DIV0;
        end else if (ovf) begin
          res_num_r <= '0;
          res_den_r <= '0;
          status_r  <= rau_pkg::ST_OVF;
        end else begin
          res_num_r <= neg_r ? rau_pkg::NUM_W'(-qn_r) : rau_pkg::NUM_W'(qn_r);
          res_den_r <= qd_r[rau_pkg::DEN_W-1:0];
          status_r  <= rau_pkg::ST_OK;
        end
      end
      default: ;
    endcase
  end

  assign sts.both_even = !(u_r[0] | v_r[0]);
  assign sts.u_even    = !u_r[0];
  assign sts.v_zero    = (v_r == '0);
  assign sts.div_last  = (cnt_r == '1);
  assign sts.early     = early_r;

  assign res_num = res_num_r;
  assign res_den = res_den_r;
  assign status  = status_r;

  a_gstep_u_odd: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd == rau_pkg::C_GSTEP) |-> u_r[0])
    else $error("gcd step with even u");
  a_div_by_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd == rau_pkg::C_DSTEP) |-> (g_r != '0))
    else $error("division by zero gcd");
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd == rau_pkg::C_FIN) |=> (status_r == rau_pkg::ST_OK ||
      status_r == rau_pkg::ST_DIV0 || status_r == rau_pkg::ST_OVF))
    else $error("bad status code");

endmodule

// ===== rtl/rau_ctrl.sv =====
// ----------------------------------------------------------------------------
// rau_ctrl
// Controller: sequences the datapath through products, gcd and division, and
// holds the channel handshakes.
// ----------------------------------------------------------------------------
module rau_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  input  rau_pkg::rau_sts_t  sts,
  output rau_pkg::rau_cmd_t  cmd
);

  typedef enum logic [3:0] {
    S_IDLE, S_M0, S_M1, S_M2, S_M3, S_MAG, S_GINIT, S_GTWO, S_GODD,
    S_GSTEP, S_GFIN, S_DINIT, S_DSTEP, S_FIN
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   fin_ok;

  assign fin_ok   = !out_valid_r || out_ready;
  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = rau_pkg::C_NONE;
    case (state_r)
      S_IDLE: if (in_valid) begin
        cmd       = rau_pkg::C_LOAD;
        state_nxt = S_M0;
      end
      S_M0: begin
        cmd       = rau_pkg::C_M0;
        state_nxt = S_M1;
      end
      S_M1: begin
        cmd       = rau_pkg::C_M1;
        state_nxt = S_M2;
      end
      S_M2: begin
        cmd       = rau_pkg::C_M2;
        state_nxt = S_M3;
      end
      S_M3: begin
        cmd       = rau_pkg::C_M3;
        state_nxt = S_MAG;
      end
      S_MAG: begin
        cmd       = rau_pkg::C_MAG;
        state_nxt = S_GINIT;
      end
      S_GINIT: begin
        cmd       = rau_pkg::C_GINIT;
        state_nxt = sts.early ? S_FIN : S_GTWO;
      end
      S_GTWO: begin
        cmd = rau_pkg::C_GTWO;
        if (!sts.both_even) state_nxt = S_GODD;
      end
      S_GODD: begin
        cmd = rau_pkg::C_GODD;
        if (!sts.u_even) state_nxt = S_GSTEP;
      end
      S_GSTEP: begin
        cmd = rau_pkg::C_GSTEP;
        if (sts.v_zero) state_nxt = S_GFIN;
      end
      S_GFIN: begin
        cmd       = rau_pkg::C_GFIN;
        state_nxt = S_DINIT;
      end
      S_DINIT: begin
        cmd       = rau_pkg::C_DINIT;
        state_nxt = S_DSTEP;
      end
      S_DSTEP: begin
        cmd = rau_pkg::C_DSTEP;
        if (sts.div_last) state_nxt = S_FIN;
      end
      S_FIN: if (fin_ok) begin
        cmd       = rau_pkg::C_FIN;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r && !out_ready;
    if (state_r == S_FIN && fin_ok) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == S_M0))
    else $error("accepted transaction did not start");
  a_result_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_FIN))
    else $error("result shown without finish");
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd == rau_pkg::C_FIN) |-> (!out_valid_r || out_ready))
    else $error("pending result overwritten");

endmodule

// ===== rtl/rational_arithmetic_unit.sv =====
// ----------------------------------------------------------------------------
// rational_arithmetic_unit
// Exact add, subtract, multiply and divide of two fractions, reduced to
// lowest terms by a binary gcd.
//
// Usage:
//   in_chan carries op and the two fractions; a transaction is taken when
//   valid and ready are both high. out_chan returns one result transaction
//   per input: reduced numerator, denominator and status (ok, divide by
//   zero, overflow against WIDTH).
//   One transaction is processed at a time. Zero and divide-by-zero
//   results skip the gcd and the division; all others run the products,
//   the gcd loop of shift and subtract steps and the division. The shared
//   32x32 multiplier, the one-step gcd unit and the 64-step bit-serial
//   dividers set how long a transaction takes.
//   in ready is high while the block is idle, also while a finished result
//   waits; a stalled receiver holds the result and the next transaction
//   runs up to its final step, then waits until the result is taken.
//   Synchronous active-low reset returns to idle with no result pending.
// ----------------------------------------------------------------------------
module rational_arithmetic_unit #(
  parameter int WIDTH = rau_pkg::RES_W_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  rau_in_if.sink    in_chan,
  rau_out_if.source out_chan
);

  rau_pkg::rau_cmd_t cmd;
  rau_pkg::rau_sts_t sts;

  rau_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_ready  (in_chan.ready),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  rau_dp #(.WIDTH(WIDTH)) u_dp (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (cmd),
    .op      (in_chan.op),
    .a_num   (in_chan.a_num),
    .a_den   (in_chan.a_den),
    .b_num   (in_chan.b_num),
    .b_den   (in_chan.b_den),
    .sts     (sts),
    .res_num (out_chan.res_num),
    .res_den (out_chan.res_den),
    .status  (out_chan.status)
  );

endmodule
